// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker of the run-length encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rdce_pkg.sv =====
// Package with types, constants and digit helpers of the run-length encoder.
`timescale 1ns / 1ps
package rdce_pkg;

	localparam int RDCE_CNT_W   = 16;
	localparam int RDCE_MAX_RUN = 65535;
	localparam int RDCE_QDEPTH  = 4;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_UC_A = 8'h41;
	localparam logic [7:0] ASCII_UC_Z = 8'h5A;
	localparam logic [7:0] ASCII_LC_A = 8'h61;
	localparam logic [7:0] ASCII_LC_Z = 8'h7A;

	// One flush command: a run to spell out and an optional single byte after it.
	typedef struct packed {
		logic [7:0]            sym1;
		logic [RDCE_CNT_W-1:0] cnt1;
		logic                  has2;
		logic [7:0]            sym2;
		logic                  eop;
	} cmd_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_DIGIT,
		PH_TAIL
	} phase_t;

	function automatic logic is_letter(logic [7:0] b);
		return ((b >= ASCII_UC_A) && (b <= ASCII_UC_Z)) ||
		       ((b >= ASCII_LC_A) && (b <= ASCII_LC_Z));
	endfunction

	// Position of the leading decimal digit of a count.
	function automatic logic [2:0] dec_npos(logic [RDCE_CNT_W-1:0] v);
		logic [2:0] p;
		if (v >= 16'd10000) begin
			p = 3'd4;
		end else if (v >= 16'd1000) begin
			p = 3'd3;
		end else if (v >= 16'd100) begin
			p = 3'd2;
		end else if (v >= 16'd10) begin
			p = 3'd1;
		end else begin
			p = 3'd0;
		end
		return p;
	endfunction

	// Digit value times the power of ten of its position.
	function automatic logic [16:0] dec_scale(logic [3:0] k, logic [2:0] p);
		logic [16:0] r;
		case (p)
			3'd0: r = 17'(k);
			3'd1: r = 17'(k) * 17'd10;
			3'd2: r = 17'(k) * 17'd100;
			3'd3: r = 17'(k) * 17'd1000;
			3'd4: r = 17'(k) * 17'd10000;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Decimal digit at position p, for a value below ten times that place.
	function automatic logic [3:0] dec_digit(logic [RDCE_CNT_W-1:0] v, logic [2:0] p);
		logic [3:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({1'b0, v} >= dec_scale(4'(k), p)) begin
				d = 4'(k);
			end
		end
		return d;
	endfunction

endpackage

// ===== rtl/core/rdce_front.sv =====
// Front end: configuration register, filtering, run tracking and flush commands.
`timescale 1ns / 1ps
module rdce_front
	import rdce_pkg::*;
#(
	parameter int MAX_RUN = RDCE_MAX_RUN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic                  filter_q;
	logic [7:0]            run_sym_q;
	logic [RDCE_CNT_W-1:0] run_cnt_q;
	logic                  accept;
	logic                  keep;
	logic                  flush_old;
	logic [7:0]            new_sym;
	logic [RDCE_CNT_W-1:0] new_cnt;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign keep      = !filter_q || is_letter(s_tdata);
	assign flush_old = keep && (run_cnt_q != '0) &&
	                   ((s_tdata != run_sym_q) || (run_cnt_q >= RDCE_CNT_W'(MAX_RUN)));

	always_comb begin
		new_sym = run_sym_q;
		new_cnt = run_cnt_q;
		if (keep) begin
			if (flush_old || (run_cnt_q == '0)) begin
				new_sym = s_tdata;
				new_cnt = RDCE_CNT_W'(1);
			end else begin
				new_cnt = run_cnt_q + RDCE_CNT_W'(1);
			end
		end
	end

	assign push          = accept && (flush_old || (s_tlast && (new_cnt != '0)));
	assign push_cmd.sym1 = flush_old ? run_sym_q : new_sym;
	assign push_cmd.cnt1 = flush_old ? run_cnt_q : new_cnt;
	assign push_cmd.has2 = flush_old && s_tlast;
	assign push_cmd.sym2 = s_tdata;
	assign push_cmd.eop  = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q  <= 1'b1;
			run_sym_q <= '0;
			run_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				filter_q <= cfg_data;
			end
			if (accept) begin
				run_sym_q <= new_sym;
				run_cnt_q <= s_tlast ? '0 : new_cnt;
			end
		end
	end

endmodule

// ===== rtl/core/rdce_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module rdce_queue
	import rdce_pkg::*;
#(
	parameter int QDEPTH = RDCE_QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == CNT_W'(QDEPTH));
	assign empty   = (fill_q == '0);
	assign head    = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/rdce_back.sv =====
// Back end: spells each command to the output register, one word per unstalled cycle.
`timescale 1ns / 1ps
module rdce_back
	import rdce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  cmd_t       head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [0:0] m_tuser
);

	phase_t                phase_q;
	phase_t                phase_d;
	logic                  sel2_q;
	logic                  sel2_d;
	logic [RDCE_CNT_W-1:0] val_q;
	logic [2:0]            pos_q;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  m_tlast_q;
	logic                  m_tuser_q;
	logic                  advance;
	logic [RDCE_CNT_W-1:0] dig_val;
	logic [2:0]            dig_pos;
	logic [3:0]            dig;
	logic [RDCE_CNT_W-1:0] dig_rem;
	logic [7:0]            out_sym;
	logic                  run_done;
	logic                  item_done;

	assign advance = !empty && (!m_tvalid_q || m_tready);
	assign dig_val = (phase_q == PH_START) ? head.cnt1 : val_q;
	assign dig_pos = (phase_q == PH_START) ? dec_npos(head.cnt1) : pos_q;
	assign dig     = dec_digit(dig_val, dig_pos);
	assign dig_rem = RDCE_CNT_W'({1'b0, dig_val} - dec_scale(dig, dig_pos));

	always_comb begin
		phase_d = phase_q;
		sel2_d  = sel2_q;
		case (phase_q)
			PH_START: begin
				if (sel2_q) begin
					sel2_d = 1'b0;
				end else if (head.cnt1 == RDCE_CNT_W'(1)) begin
					sel2_d = head.has2;
				end else if (head.cnt1 == RDCE_CNT_W'(2)) begin
					phase_d = PH_TAIL;
				end else begin
					phase_d = (dig_pos == 3'd0) ? PH_TAIL : PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				phase_d = (pos_q == 3'd0) ? PH_TAIL : PH_DIGIT;
			end
			PH_TAIL: begin
				phase_d = PH_START;
				sel2_d  = head.has2;
			end
			default: begin
				phase_d = PH_START;
				sel2_d  = 1'b0;
			end
		endcase
	end

	always_comb begin
		out_sym  = head.sym1;
		run_done = 1'b0;
		case (phase_q)
			PH_START: begin
				if (sel2_q) begin
					out_sym  = head.sym2;
					run_done = 1'b1;
				end else if (head.cnt1 <= RDCE_CNT_W'(2)) begin
					out_sym  = head.sym1;
					run_done = (head.cnt1 == RDCE_CNT_W'(1));
				end else begin
					out_sym  = ASCII_ZERO + 8'(dig);
				end
			end
			PH_DIGIT: begin
				out_sym = ASCII_ZERO + 8'(dig);
			end
			PH_TAIL: begin
				out_sym  = head.sym1;
				run_done = 1'b1;
			end
			default: begin
				out_sym  = head.sym1;
				run_done = 1'b0;
			end
		endcase
	end

	assign item_done = run_done && (sel2_q || !head.has2);
	assign pop       = advance && item_done;

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= out_sym;
			m_tuser_q <= item_done;
			m_tlast_q <= item_done && head.eop;
			val_q     <= dig_rem;
			pos_q     <= dig_pos - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			sel2_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= phase_d;
				sel2_q     <= sel2_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tlast    = m_tlast_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

// ===== rtl/core/rle_decimal_count_encoder.sv =====
// Top level of the run-length encoder with decimal ASCII run counts.
//
//   channel   direction   words carried
//   cfg       in          filter enable bit
//   s_axis    in          one raw byte, tlast closes the part
//   m_axis    out         one encoded byte, tuser marks an item's final word
//
// An input word is taken every cycle while the command queue has room.
// The back end sends one output word per cycle unless stalled, so an item
// is up to 7 output words; a count above two takes one word per digit.
// The queue holds QDEPTH flush commands and lets the two sides stall apart.
// Reset clears the run state and the queue and sets filtering on.
`timescale 1ns / 1ps
module rle_decimal_count_encoder
	import rdce_pkg::*;
#(
	parameter int MAX_RUN = RDCE_MAX_RUN,
	parameter int QDEPTH  = RDCE_QDEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic [0:0] m_tuser    // [0] last_of_item
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t head;

	rdce_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.q_full(q_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	rdce_queue #(
		.QDEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.head(head)
	);

	rdce_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(q_empty),
		.head(head),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

// ===== rtl/core/rdce_checker.sv =====
// Port checker of the run-length encoder and its binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rdce_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [0:0] m_tuser
);

	// The final word of a part is always the final word of its item.
	`ASSERT_CLK(a_eop_ends_item, m_tvalid && m_tlast |-> m_tuser[0], "end of part without item end")

	// A stalled word stays offered and unchanged.
	`ASSERT_CLK(a_hold_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled word changed")

	// No word is offered while reset is applied.
	`ASSERT_ALWAYS(a_quiet_reset, !arst_n |-> !m_tvalid, "word offered during reset")

endmodule

bind rle_decimal_count_encoder rdce_checker u_rdce_checker (.*);
